### rtl/core/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the barometric sensor compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] CFG_AC123 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_AC456 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_B12   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MCMD  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OSS   = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [18:0] raw_value;
  } in_word_t;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [47:0] ac123;
    logic [47:0] ac456;
    logic [31:0] b12;
    logic [31:0] mcmd;
    logic [1:0]  oss;
  } cal_t;

  typedef struct packed {
    logic        start;
    logic        is_signed;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

### rtl/core/barometric_sensor_compensation.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Temperature and pressure compensation of raw barometric sensor readings.
// ----------------------------------------------------------------------------
// One word at a time: each word passes through the bit-serial divider (at most
// one divide for each word) and the single shared multiplier that the sequencer
// steps through the compensation terms, which also scales the pressure to
// millibar by a reciprocal product. The result waits in the core until the
// output register takes it, at once or once a stalled output register has
// drained, and the next word is taken in the cycle after.
module barometric_sensor_compensation (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bsc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [bsc_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bsc_pkg::in_word_t                   in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bsc_pkg::out_word_t                  out_word_o
);

  bsc_pkg::cal_t      cal_q;
  logic               busy;
  logic               res_valid;
  logic               res_take;
  bsc_pkg::out_word_t res;
  logic               out_valid_q;
  bsc_pkg::out_word_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bsc_pkg::CFG_AC123: cal_q.ac123 <= cfg_data_i[47:0];
        bsc_pkg::CFG_AC456: cal_q.ac456 <= cfg_data_i[47:0];
        bsc_pkg::CFG_B12:   cal_q.b12   <= cfg_data_i[31:0];
        bsc_pkg::CFG_MCMD:  cal_q.mcmd  <= cfg_data_i[31:0];
        bsc_pkg::CFG_OSS:   cal_q.oss   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = busy;
  assign res_take   = res_valid && (!out_valid_q || !out_stall_i);

  bsc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal_q),
    .start_i     (in_valid_i && !busy),
    .word_i      (in_word_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

### rtl/core/bsc_div.sv
// ----------------------------------------------------------------------------
// bsc_div
// Iterative 32-bit divider, one quotient bit per cycle, truncating signed mode.
// ----------------------------------------------------------------------------
module bsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsc_pkg::div_req_t  req_i,
  output logic               done_o,
  output logic [31:0]        quo_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic [31:0] mag_a, mag_b;

  always_comb begin
    mag_a = (req_i.is_signed && req_i.dividend[31]) ? (32'd0 - req_i.dividend)
                                                     : req_i.dividend;
    mag_b = (req_i.is_signed && req_i.divisor[31]) ? (32'd0 - req_i.divisor)
                                                    : req_i.divisor;
    rem_sh  = {rem_q[31:0], quo_q[31]};
    rem_sub = rem_sh - {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = 33'd0;
      quo_d  = mag_a;
      den_d  = mag_b;
      neg_d  = req_i.is_signed && (req_i.dividend[31] ^ req_i.divisor[31]);
    end else if (busy_q) begin
      if (!rem_sub[32]) begin
        rem_d = rem_sub;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

### rtl/core/bsc_core.sv
// ----------------------------------------------------------------------------
// bsc_core
// Sequencer around one shared 32x32 multiplier and the divider.
// ----------------------------------------------------------------------------
module bsc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsc_pkg::cal_t       cal_i,
  input  logic                start_i,
  input  bsc_pkg::in_word_t   word_i,
  output logic                busy_o,
  output logic                res_valid_o,
  input  logic                res_take_i,
  output bsc_pkg::out_word_t  res_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] T_M    = 5'd1;
  localparam logic [4:0] T_X1   = 5'd2;
  localparam logic [4:0] T_DW   = 5'd3;
  localparam logic [4:0] P_B6   = 5'd4;
  localparam logic [4:0] P_M1   = 5'd5;
  localparam logic [4:0] P_SQ   = 5'd6;
  localparam logic [4:0] P_M2   = 5'd7;
  localparam logic [4:0] P_M3   = 5'd8;
  localparam logic [4:0] P_M4   = 5'd9;
  localparam logic [4:0] P_M5   = 5'd10;
  localparam logic [4:0] P_M6   = 5'd11;
  localparam logic [4:0] P_M7   = 5'd12;
  localparam logic [4:0] P_B4   = 5'd13;
  localparam logic [4:0] P_B7   = 5'd14;
  localparam logic [4:0] P_DW   = 5'd15;
  localparam logic [4:0] P_M8   = 5'd16;
  localparam logic [4:0] P_M9   = 5'd17;
  localparam logic [4:0] P_M10  = 5'd18;
  localparam logic [4:0] P_M11  = 5'd19;
  localparam logic [4:0] P_DW2  = 5'd20;
  localparam logic [4:0] S_OUT  = 5'd21;
  localparam logic [4:0] P_Q    = 5'd22;

  // floor(n / 100) == (n * RecipDiv100) >> 37 for any 32-bit unsigned n
  localparam logic [31:0] RecipDiv100 = 32'h51EB_851F;

  logic [4:0]  state_q, state_d;
  logic [31:0] b5_q, b5_d;
  logic [31:0] prod_q;
  logic [26:0] prod_hi_q;
  logic [63:0] prod_full;
  logic [31:0] mul_a, mul_b;
  logic [31:0] r1_q, r1_d;
  logic [31:0] b6_q, b6_d;
  logic [31:0] sq_q, sq_d;
  logic [31:0] b3_q, b3_d;
  logic [31:0] p_q, p_d;
  logic        hi_q, hi_d;
  logic [18:0] raw_q, raw_d;
  logic [31:0] res_q, res_d;
  logic [1:0]  st_q, st_d;
  bsc_pkg::div_req_t div_req;
  logic        div_done;
  logic [31:0] div_quo;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] t_x1, t_div, t_b5, x3, b3v, x3b, b4v, pnew, p8;
  logic [31:0] sh11, sh16, t_acc, p_acc, p_abs, q100;

  always_comb begin
    ac1 = {{16{cal_i.ac123[47]}}, cal_i.ac123[47:32]};
    ac2 = {{16{cal_i.ac123[31]}}, cal_i.ac123[31:16]};
    ac3 = {{16{cal_i.ac123[15]}}, cal_i.ac123[15:0]};
    ac4 = {16'd0, cal_i.ac456[47:32]};
    ac5 = {16'd0, cal_i.ac456[31:16]};
    ac6 = {16'd0, cal_i.ac456[15:0]};
    b1  = {{16{cal_i.b12[31]}}, cal_i.b12[31:16]};
    b2  = {{16{cal_i.b12[15]}}, cal_i.b12[15:0]};
    mc  = {{16{cal_i.mcmd[31]}}, cal_i.mcmd[31:16]};
    md  = {{16{cal_i.mcmd[15]}}, cal_i.mcmd[15:0]};
  end

  always_comb begin
    t_x1  = $signed(prod_q) >>> 15;
    t_div = t_x1 + md;
    t_b5  = r1_q + div_quo;
    t_acc = $signed(t_b5 + 32'd8) >>> 4;
    sh11  = $signed(prod_q) >>> 11;
    sh16  = $signed(prod_q) >>> 16;
    x3    = r1_q + sh11;
    b3v   = $signed((((ac1 << 2) + x3) << cal_i.oss) + 32'd2) >>> 2;
    x3b   = $signed(r1_q + sh16 + 32'd2) >>> 2;
    b4v   = prod_q >> 15;
    p8    = $signed(p_q) >>> 8;
    p_acc = $signed(r1_q + sh16 + 32'd3791) >>> 4;
    pnew  = p_q + p_acc;
    p_abs = p_q[31] ? (32'd0 - p_q) : p_q;
    q100  = {5'd0, prod_hi_q};
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_q)
      T_M:   begin mul_a = {16'd0, raw_q[15:0]} - ac6; mul_b = ac5; end
      P_M1:  begin mul_a = b6_q; mul_b = b6_q; end
      P_M2:  begin mul_a = b2;   mul_b = sq_q; end
      P_M3:  begin mul_a = ac2;  mul_b = b6_q; end
      P_M4:  begin mul_a = ac3;  mul_b = b6_q; end
      P_M5:  begin mul_a = b1;   mul_b = sq_q; end
      P_M7:  begin mul_a = ac4;  mul_b = r1_q + 32'd32768; end
      P_B4:  begin
        mul_a = {13'd0, raw_q} - b3_q;
        mul_b = 32'd50000 >> cal_i.oss;
      end
      P_M8:  begin mul_a = p8;     mul_b = p8; end
      P_M9:  begin mul_a = prod_q; mul_b = 32'd3038; end
      P_M10: begin mul_a = 32'd0 - 32'd7357; mul_b = p_q; end
      P_DW2: begin mul_a = p_abs;  mul_b = RecipDiv100; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  assign prod_full = {32'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_full[31:0];
    prod_hi_q <= prod_full[63:37];
  end

  always_comb begin
    state_d = state_q;
    b5_d    = b5_q;
    r1_d    = r1_q;
    b6_d    = b6_q;
    sq_d    = sq_q;
    b3_d    = b3_q;
    p_d     = p_q;
    hi_d    = hi_q;
    raw_d   = raw_q;
    res_d   = res_q;
    st_d    = st_q;
    div_req = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          raw_d   = word_i.raw_value;
          state_d = word_i.mode ? P_B6 : T_M;
        end
      end
      T_M: state_d = T_X1;
      T_X1: begin
        r1_d = t_x1;
        if (t_div == 32'd0) begin
          res_d   = 32'd0;
          st_d    = bsc_pkg::ST_DIV0;
          state_d = S_OUT;
        end else begin
          div_req.start     = 1'b1;
          div_req.is_signed = 1'b1;
          div_req.dividend  = mc << 11;
          div_req.divisor   = t_div;
          state_d           = T_DW;
        end
      end
      T_DW: begin
        if (div_done) begin
          b5_d    = t_b5;
          res_d   = 32'd2732 + t_acc;
          st_d    = bsc_pkg::ST_OK;
          state_d = S_OUT;
        end
      end
      P_B6: begin
        b6_d    = b5_q - 32'd4000;
        state_d = P_M1;
      end
      P_M1: state_d = P_SQ;
      P_SQ: begin
        sq_d    = $signed(prod_q) >>> 12;
        state_d = P_M2;
      end
      P_M2: state_d = P_M3;
      P_M3: begin
        r1_d    = $signed(prod_q) >>> 11;
        state_d = P_M4;
      end
      P_M4: begin
        b3_d    = b3v;
        state_d = P_M5;
      end
      P_M5: begin
        r1_d    = $signed(prod_q) >>> 13;
        state_d = P_M6;
      end
      P_M6: begin
        r1_d    = x3b;
        state_d = P_M7;
      end
      P_M7: state_d = P_B4;
      P_B4: begin
        r1_d = b4v;
        if (b4v == 32'd0) begin
          res_d   = 32'd0;
          st_d    = bsc_pkg::ST_DIV0;
          state_d = S_OUT;
        end else begin
          state_d = P_B7;
        end
      end
      P_B7: begin
        hi_d              = prod_q[31];
        div_req.start     = 1'b1;
        div_req.is_signed = 1'b0;
        div_req.dividend  = prod_q[31] ? prod_q : (prod_q << 1);
        div_req.divisor   = r1_q;
        state_d           = P_DW;
      end
      P_DW: begin
        if (div_done) begin
          p_d     = hi_q ? (div_quo << 1) : div_quo;
          state_d = P_M8;
        end
      end
      P_M8:  state_d = P_M9;
      P_M9:  state_d = P_M10;
      P_M10: begin
        r1_d    = $signed(prod_q) >>> 16;
        state_d = P_M11;
      end
      P_M11: begin
        p_d     = pnew;
        state_d = P_DW2;
      end
      P_DW2: state_d = P_Q;
      P_Q: begin
        res_d   = p_q[31] ? (32'd0 - q100) : q100;
        st_d    = bsc_pkg::ST_OK;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      b5_q    <= 32'd0;
    end else begin
      state_q <= state_d;
      b5_q    <= b5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q  <= r1_d;
    b6_q  <= b6_d;
    sq_q  <= sq_d;
    b3_q  <= b3_d;
    p_q   <= p_d;
    hi_q  <= hi_d;
    raw_q <= raw_d;
    res_q <= res_d;
    st_q  <= st_d;
  end

  bsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    res_o.status = st_q;
    res_o.value  = res_q[15:0];
    if (st_q == bsc_pkg::ST_OK) begin
      if (res_q[31]) begin
        res_o.value  = 16'd0;
        res_o.status = bsc_pkg::ST_SAT;
      end else if (res_q[31:16] != 16'd0) begin
        res_o.value  = 16'hFFFF;
        res_o.status = bsc_pkg::ST_SAT;
      end
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_OUT);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (state_q == T_X1 || state_q == P_B7))
    else $error("divider started outside a divide step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b5_q != $past(b5_q)) |-> ($past(state_q) == T_DW))
    else $error("b5 changed outside temperature completion");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !res_take_i) |=> (state_q == S_OUT))
    else $error("result dropped before taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_DW || state_q == P_DW) && !div_done |=>
      (state_q == $past(state_q)))
    else $error("divide wait left early");

endmodule
